FILE: rtl/ue_pkg.sv
// Shared types, codes and character helpers for the URL percent encoder.
// Used by ue_front, ue_queue, ue_back and url_percent_encoder_core.
package ue_pkg;

    // Configuration register indexes
    localparam logic CFG_PASS_CHAR  = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    localparam int PASS_BITS = 8;
    localparam int MAXLEN_BITS = 16;
    localparam int CFG_DATA_BITS = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // Work classes handed from front to back
    typedef enum logic [1:0] {
        OP_COPY = 2'b00,
        OP_ESC  = 2'b01,
        OP_TERM = 2'b10
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       status;
    } q_entry_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
            return wide + 8'h30;
        else
            return wide + 8'h37;
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c, input logic [7:0] pass);
        logic hit;
        hit = ((c >= 8'h30) && (c <= 8'h39)) ||
              ((c >= 8'h41) && (c <= 8'h5A)) ||
              ((c >= 8'h61) && (c <= 8'h7A)) ||
              (c == CHAR_DOT) || (c == CHAR_DASH) ||
              (c == CHAR_UNDER) || (c == CHAR_TILDE) ||
              ((pass != CHAR_NUL) && (c == pass));
        return hit;
    endfunction

endpackage

FILE: rtl/ue_front.sv
// Front end: accepts input words, tracks length and overflow, classifies.
// Depends on ue_pkg.
module ue_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                end_mark,
    input  logic [7:0]          pass_char,
    input  logic [15:0]         max_length,
    output logic                push,
    output ue_pkg::q_entry_t    push_entry
);

    localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  over_reg, over_next;
    logic                  at_limit;

    assign at_limit = CMP_BITS'(count_reg) >= CMP_BITS'(max_length);

    always_comb
    begin
        count_next = count_reg;
        over_next  = over_reg;
        push       = 1'b0;
        push_entry.op     = ue_pkg::OP_COPY;
        push_entry.data   = in_byte;
        push_entry.status = 1'b0;
        if (accept)
        begin
            if (end_mark)
            begin
                // end of string: clear, terminate unless already terminated
                count_next = '0;
                over_next  = 1'b0;
                push       = !over_reg;
                push_entry.op   = ue_pkg::OP_TERM;
                push_entry.data = ue_pkg::CHAR_NUL;
            end
            else if (!over_reg)
            begin
                push = 1'b1;
                if (at_limit)
                begin
                    over_next = 1'b1;
                    push_entry.op     = ue_pkg::OP_TERM;
                    push_entry.data   = ue_pkg::CHAR_NUL;
                    push_entry.status = 1'b1;
                end
                else
                begin
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + 1'b1;
                    if (!ue_pkg::is_unreserved(in_byte, pass_char))
                        push_entry.op = ue_pkg::OP_ESC;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            over_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            over_reg  <= over_next;
        end
    end

endmodule

FILE: rtl/ue_queue.sv
// Short queue of classified words between front and back.
// Depends on ue_pkg.
module ue_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ue_pkg::q_entry_t    push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ue_pkg::q_entry_t    head
);

    ue_pkg::q_entry_t store_reg [ue_pkg::QUEUE_DEPTH];
    logic [ue_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ue_pkg::QUEUE_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full       = cnt_reg == ue_pkg::QUEUE_CNT_BITS'(ue_pkg::QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/ue_back.sv
// Back end: expands queued work into output characters through an output register.
// Depends on ue_pkg.
module ue_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ue_pkg::q_entry_t    head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                is_terminator,
    output logic                status
);

    logic [1:0] phase_reg, phase_next;
    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       term_reg, term_next;
    logic       stat_reg, stat_next;
    logic       slot_free, load;

    assign slot_free = !valid_reg || !out_stall;
    assign load      = head_valid && slot_free;

    always_comb
    begin
        byte_next  = head.data;
        last_next  = 1'b1;
        term_next  = 1'b0;
        stat_next  = 1'b0;
        phase_next = phase_reg;
        case (head.op)
            ue_pkg::OP_COPY:
            begin
                byte_next = head.data;
            end
            ue_pkg::OP_ESC:
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        byte_next = ue_pkg::CHAR_PERCENT;
                        last_next = 1'b0;
                    end
                    2'd1:
                    begin
                        byte_next = ue_pkg::hex_digit(head.data[7:4]);
                        last_next = 1'b0;
                    end
                    default:
                    begin
                        byte_next = ue_pkg::hex_digit(head.data[3:0]);
                    end
                endcase
            end
            ue_pkg::OP_TERM:
            begin
                byte_next = ue_pkg::CHAR_NUL;
                term_next = 1'b1;
                stat_next = head.status;
            end
            default:
            begin
                byte_next = head.data;
            end
        endcase
        pop = load && last_next;
        if (load)
            phase_next = last_next ? 2'd0 : phase_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            term_reg <= term_next;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (slot_free)
                valid_reg <= head_valid;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign run_last      = last_reg;
    assign is_terminator = term_reg;
    assign status        = stat_reg;

endmodule

FILE: rtl/url_percent_encoder_core.sv
// Top level of the URL percent encoder: config registers, front, queue, back.
// Depends on ue_pkg, ue_front, ue_queue, ue_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | into      | in_valid/in_stall  | in_byte, end_mark
//  out     | out of    | out_valid/out_stall| out_byte, run_last, is_terminator, status
//  cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// A plain or terminating word leaves as one output character, an escaped byte as three
// ('%' and two hex digits), each through the one-word output register.
// The front takes a new word every cycle while the four-entry queue has room.
// Output stall holds the output register; input stall rises only on a full queue.
// Reset clears the count, the overflow flag, the queue and the output valid flag;
// pass_char resets to zero and max_length to 65535.
module url_percent_encoder_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_mark,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        is_terminator,
    output logic        status,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  pass_char_reg;
    logic [15:0] max_length_reg;

    logic             accept;
    logic             push, q_full, pop, head_valid;
    ue_pkg::q_entry_t push_entry, head;

    // Configuration registers: the user must write them only while idle; not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_char_reg  <= 8'h00;
            max_length_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ue_pkg::CFG_PASS_CHAR:  pass_char_reg  <= cfg_data[7:0];
                ue_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                default:                pass_char_reg  <= pass_char_reg;
            endcase
        end
    end

    // Stall the front only when the queue cannot take another word
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    ue_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .end_mark   (end_mark),
        .pass_char  (pass_char_reg),
        .max_length (max_length_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    ue_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ue_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .is_terminator (is_terminator),
        .status        (status)
    );

endmodule

FILE: rtl/ue_checker.sv
// Port-level checks for url_percent_encoder_core, attached by bind.
// Depends on the top level's port list only.
module ue_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       is_terminator,
    input logic       status
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled output word changed");

    // A terminator carries a zero byte and closes its run
    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_terminator |-> out_byte == 8'h00 && run_last)
        else $error("malformed terminator");

    // Status only flags terminators
    a_status_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_terminator |-> !status)
        else $error("status set on a data word");

    // Output valid is always known once out of reset
    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(out_valid))
        else $error("output valid unknown");

endmodule

bind url_percent_encoder_core ue_checker u_ue_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .is_terminator (is_terminator),
    .status        (status)
);

FILE: dv/url_percent_encoder_core_tb.sv
// Self-checking testbench for url_percent_encoder_core: random strings under several
// pass_char / max_length settings, checked character by character. Depends on ue_pkg.
`timescale 1ns / 100ps

module url_percent_encoder_core_tb;

    localparam int COUNT_BITS   = 16;
    localparam int LIMIT_CYCLES = 50000;
    // Words that end in a dropped byte produce nothing; give the four-entry
    // queue and the output register time to empty before a register write.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 80;
    localparam logic [127:0] HEX_ASCII = "0123456789ABCDEF";

    typedef struct packed {
        logic [7:0] data;
        logic       endm;
    } raw_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       term;
        logic       st;
    } enc_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        end_mark = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        is_terminator;
    logic        status;
    logic        cfg_we = 1'b0;
    logic        cfg_index = ue_pkg::CFG_PASS_CHAR;
    logic [15:0] cfg_data = 16'h0000;

    url_percent_encoder_core #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_mark     (end_mark),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .is_terminator(is_terminator),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Words waiting to be sent, and encoded characters waiting to come out.
    raw_word_t raw_words[$];
    enc_char_t exp_chars[$];

    // Shadow of the encoder: registers and per-string state.
    logic [7:0]            pass_c  = 8'h00;
    logic [15:0]           max_len = 16'hFFFF;
    logic [COUNT_BITS-1:0] str_len = '0;
    logic                  str_over = 1'b0;

    logic in_taken = 1'b0;
    logic gaps_on  = 1'b0;
    int   hold_requests = 0;
    int   holds_done = 0;
    int   cycles = 0;
    int   fails = 0;
    int   words_in = 0;
    int   chars_out = 0;
    int   strings_ok = 0;
    int   strings_long = 0;

    function automatic logic copies_plain(input logic [7:0] c);
        if (pass_c != ue_pkg::CHAR_NUL && c == pass_c)
            return 1'b1;
        case (c)
            ue_pkg::CHAR_DOT, ue_pkg::CHAR_DASH, ue_pkg::CHAR_UNDER, ue_pkg::CHAR_TILDE:
                return 1'b1;
            default:
                return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                       (c >= "a" && c <= "z");
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_ASCII[(15 - nib) * 8 +: 8];
    endfunction

    // Work out what one accepted word must produce and queue it.
    task automatic encode_word(input logic [7:0] c, input logic endm);
        logic was_over;
        if (endm)
        begin
            was_over = str_over;
            str_len  = '0;
            str_over = 1'b0;
            // a string already cut short by the length limit has had its terminator
            if (!was_over)
            begin
                exp_chars.push_back('{ue_pkg::CHAR_NUL, 1'b1, 1'b1, 1'b0});
                strings_ok++;
            end
        end
        else if (!str_over)
        begin
            if (str_len >= max_len)
            begin
                str_over = 1'b1;
                exp_chars.push_back('{ue_pkg::CHAR_NUL, 1'b1, 1'b1, 1'b1});
                strings_long++;
            end
            else
            begin
                // saturate the count rather than wrap
                if (str_len != '1)
                    str_len = str_len + 1'b1;
                if (copies_plain(c))
                begin
                    exp_chars.push_back('{c, 1'b1, 1'b0, 1'b0});
                end
                else
                begin
                    exp_chars.push_back('{ue_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0});
                    exp_chars.push_back('{hex_char(c[7:4]), 1'b0, 1'b0, 1'b0});
                    exp_chars.push_back('{hex_char(c[3:0]), 1'b1, 1'b0, 1'b0});
                end
            end
        end
    endtask

    // Monitor: check the output word first, then record the input word and any
    // register write of this edge, so an output never meets its own expectation early.
    always @(posedge clk)
    begin : monitor_proc
        enc_char_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                chars_out++;
                if (exp_chars.size() == 0)
                begin
                    $error("unexpected output word: out_byte %h", out_byte);
                    fails++;
                end
                else
                begin
                    want = exp_chars.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        $error("out_byte: expected %h, got %h", want.ch, out_byte);
                        fails++;
                    end
                    if (run_last !== want.last)
                    begin
                        $error("run_last: expected %b, got %b", want.last, run_last);
                        fails++;
                    end
                    if (is_terminator !== want.term)
                    begin
                        $error("is_terminator: expected %b, got %b", want.term,
                               is_terminator);
                        fails++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %b, got %b", want.st, status);
                        fails++;
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                words_in++;
                encode_word(in_byte, end_mark);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ue_pkg::CFG_PASS_CHAR:  pass_c = cfg_data[7:0];
                    ue_pkg::CFG_MAX_LENGTH: max_len = cfg_data;
                    default:                pass_c = pass_c;
                endcase
            end
        end
    end

    // Driver: hold a stalled word, otherwise advance to the next queued word,
    // with random gaps between words while gaps are enabled.
    int send_gap = 0;

    always @(negedge clk)
    begin : driver_proc
        raw_word_t w;
        logic      next_valid;
        if (rst_n && (!in_valid || in_taken))
        begin
            next_valid = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (raw_words.size() > 0)
            begin
                w = raw_words.pop_front();
                in_byte  <= w.data;
                end_mark <= w.endm;
                next_valid = 1'b1;
                if (gaps_on && $urandom_range(0, 6) == 0)
                    send_gap = $urandom_range(1, 13);
            end
            in_valid <= next_valid;
        end
    end

    // Long hold-off on request, counted here so the queue fills and the
    // block has to stall its input.
    int hold_left = 0;

    always @(posedge clk)
    begin : hold_proc
        if (hold_left > 0)
        begin
            hold_left--;
        end
        else if (holds_done != hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
    end

    // Receiver: stall through a hold-off, otherwise in random bursts while gaps are enabled.
    int stall_left = 0;

    always @(negedge clk)
    begin : receiver_proc
        logic next_stall;
        if (rst_n)
        begin
            next_stall = 1'b0;
            if (hold_left > 0)
            begin
                next_stall = 1'b1;
            end
            else if (gaps_on)
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    next_stall = 1'b1;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 13) - 1;
                    next_stall = 1'b1;
                end
            end
            out_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_word(input logic [7:0] b, input logic e);
        raw_words.push_back('{b, e});
    endtask

    function automatic logic [7:0] random_plain_char();
        int r;
        r = $urandom_range(0, 65);
        if (r < 26)
            return 8'h41 + r[7:0];
        if (r < 52)
            return 8'h61 + r[7:0] - 8'd26;
        if (r < 62)
            return 8'h30 + r[7:0] - 8'd52;
        case (r)
            62: return ue_pkg::CHAR_DOT;
            63: return ue_pkg::CHAR_DASH;
            64: return ue_pkg::CHAR_UNDER;
            default: return ue_pkg::CHAR_TILDE;
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return random_plain_char();
            4: return (pass_c != ue_pkg::CHAR_NUL) ? pass_c : 8'($urandom_range(0, 255));
            5: return ue_pkg::CHAR_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue whole strings with random content, up to max_len + 3 long under a limit below ten, else up to 12.
    // Now and then drop the end mark so a string runs on into the next.
    task automatic push_strings(input int n_words);
        int pushed;
        int len;
        int span;
        pushed = 0;
        while (pushed < n_words)
        begin
            span = (max_len < 16'd10) ? int'(max_len) + 3 : 12;
            len = $urandom_range(0, span);
            for (int k = 0; k < len; k++)
            begin
                push_word(random_byte(), 1'b0);
                pushed++;
            end
            if ($urandom_range(0, 9) != 0)
            begin
                push_word(8'($urandom_range(0, 255)), 1'b1);
                pushed++;
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every word is sent and every character has come out, then settle.
    task automatic drain();
        while (raw_words.size() != 0 || in_valid || exp_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every unreserved class, zero byte, non-ASCII, and
        // bytes that look special but get escaped with no pass character.
        push_word("a", 1'b0);
        push_word("Z", 1'b0);
        push_word("0", 1'b0);
        push_word("9", 1'b0);
        push_word(ue_pkg::CHAR_DOT, 1'b0);
        push_word(ue_pkg::CHAR_DASH, 1'b0);
        push_word(ue_pkg::CHAR_UNDER, 1'b0);
        push_word(ue_pkg::CHAR_TILDE, 1'b0);
        push_word(ue_pkg::CHAR_NUL, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(ue_pkg::CHAR_PERCENT, 1'b0);
        push_word("/", 1'b0);
        push_word(8'hFF, 1'b1);
        push_word(8'h00, 1'b1);
        drain();

        // Zero limit: the first byte of each string overflows.
        write_reg(ue_pkg::CFG_PASS_CHAR, 16'h002F);
        write_reg(ue_pkg::CFG_MAX_LENGTH, 16'h0000);
        push_word("/", 1'b0);
        push_word("a", 1'b0);
        push_word(8'h00, 1'b1);
        push_word(8'h00, 1'b1);
        drain();

        // Limit of two, with the pass character copied.
        write_reg(ue_pkg::CFG_MAX_LENGTH, 16'h0002);
        push_word("x", 1'b0);
        push_word("/", 1'b0);
        push_word(8'h41, 1'b0);
        push_word("b", 1'b0);
        push_word(8'hFF, 1'b1);
        drain();

        gaps_on = 1'b1;
        write_reg(ue_pkg::CFG_PASS_CHAR, 16'h00FF);
        write_reg(ue_pkg::CFG_MAX_LENGTH, 16'h0005);
        push_strings(42);
        hold_requests++;
        drain();

        write_reg(ue_pkg::CFG_PASS_CHAR, 16'h0000);
        write_reg(ue_pkg::CFG_MAX_LENGTH, 16'hFFFF);
        push_strings(42);
        drain();

        write_reg(ue_pkg::CFG_PASS_CHAR, 16'($urandom_range(1, 255)));
        write_reg(ue_pkg::CFG_MAX_LENGTH, 16'($urandom_range(1, 8)));
        push_strings(48);
        drain();

        // Last stretch at full rate on both sides.
        gaps_on = 1'b0;
        write_reg(ue_pkg::CFG_PASS_CHAR, 16'($urandom_range(0, 255)));
        write_reg(ue_pkg::CFG_MAX_LENGTH, 16'($urandom_range(0, 20)));
        push_strings(42);
        drain();

        if (exp_chars.size() != 0)
        begin
            $error("%0d encoded characters never arrived", exp_chars.size());
            fails++;
        end
        $display("sent %0d words, checked %0d output characters", words_in, chars_out);
        $display("strings ended normally: %0d, cut at the length limit: %0d",
                 strings_ok, strings_long);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
